// File: rtl/icodp_pkg.sv
`default_nettype none

package icodp_pkg;

    localparam int FILE_LENGTH_W = 31;
    localparam int HEADER_LEN    = 6;
    localparam int ENTRY_LEN     = 16;
    // Offset just past the first directory entry.
    localparam int FIRST_END     = HEADER_LEN + ENTRY_LEN;

    typedef enum logic [2:0] {
        ST_ENTRY   = 3'd0,
        ST_DONE    = 3'd1,
        ST_SHORT   = 3'd2,
        ST_SIG     = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_RSV     = 3'd5,
        ST_PAYLOAD = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_ENTRY  = 3'b010,
        PH_IDLE   = 3'b100
    } phase_t;

    typedef struct packed {
        status_t                  status;
        logic [15:0]              entry_index;
        logic [8:0]               width;
        logic [8:0]               height;
        logic [7:0]               color_count;
        logic [15:0]              planes;
        logic [15:0]              bits_per_pixel;
        logic [FILE_LENGTH_W-1:0] payload_length;
        logic [FILE_LENGTH_W-1:0] payload_offset;
        logic                     last_of_run;
    } result_t;

    // Icon signature: 00 00 01 00.
    localparam logic [7:0] ICON_SIG [4] = '{8'h00, 8'h00, 8'h01, 8'h00};

    function automatic result_t make_result(input status_t st, input logic [15:0] idx);
        result_t r;
        r             = '0;
        r.status      = st;
        r.entry_index = idx;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/icodp_parser.sv
`default_nettype none

module icodp_parser (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              fire,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              file_start,
    input  wire logic [icodp_pkg::FILE_LENGTH_W-1:0] file_length,
    output logic [1:0]                             n_results,
    output icodp_pkg::result_t                     res0,
    output icodp_pkg::result_t                     res1
);
    import icodp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_pos_reg, hdr_pos_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] num_reg, num_next;
    logic [3:0]  ent_pos_reg, ent_pos_next;
    logic [7:0]  buf_reg [0:ENTRY_LEN-2];

    phase_t      eff_phase;
    logic [2:0]  hp;
    logic [15:0] ec;
    logic [15:0] en;
    logic [15:0] en1;
    logic [3:0]  ep;
    logic [15:0] hdr_count;
    logic [20:0] next_end;
    logic [31:0] len32;
    logic [31:0] off32;
    logic [31:0] span;
    logic        pay_bad;
    logic        buf_we;
    result_t     ent_res;

    // A file start resets the walk before this byte is looked at.
    assign eff_phase = file_start ? PH_HEADER : phase_reg;
    assign hp        = file_start ? 3'd0 : hdr_pos_reg;
    assign ec        = file_start ? 16'd0 : count_reg;
    assign en        = file_start ? 16'd0 : num_reg;
    assign ep        = file_start ? 4'd0 : ent_pos_reg;
    assign en1       = en + 16'd1;
    assign hdr_count = {data_byte, ec[7:0]};
    assign next_end  = {1'b0, en1, 4'b0000} + 21'(FIRST_END);

    assign len32   = {buf_reg[11], buf_reg[10], buf_reg[9], buf_reg[8]};
    assign off32   = {data_byte, buf_reg[14], buf_reg[13], buf_reg[12]};
    assign span    = {1'b0, off32[30:0]} + {1'b0, len32[30:0]};
    assign pay_bad = len32[31] | off32[31] | (span > {1'b0, file_length});

    always_comb
    begin
        ent_res                = make_result(ST_ENTRY, en);
        ent_res.width          = (buf_reg[0] == 8'd0) ? 9'd256 : {1'b0, buf_reg[0]};
        ent_res.height         = (buf_reg[1] == 8'd0) ? 9'd256 : {1'b0, buf_reg[1]};
        ent_res.color_count    = buf_reg[2];
        ent_res.planes         = {buf_reg[5], buf_reg[4]};
        ent_res.bits_per_pixel = {buf_reg[7], buf_reg[6]};
        ent_res.payload_length = len32[30:0];
        ent_res.payload_offset = off32[30:0];
    end

    always_comb
    begin
        phase_next   = eff_phase;
        hdr_pos_next = hp;
        count_next   = ec;
        num_next     = en;
        ent_pos_next = ep;
        n_results    = 2'd0;
        res0         = make_result(ST_ENTRY, 16'd0);
        res1         = make_result(ST_ENTRY, 16'd0);
        buf_we       = 1'b0;

        unique case (eff_phase)
            PH_HEADER:
            begin
                hdr_pos_next = hp + 3'd1;
                if (hp == 3'd0 && file_length < FILE_LENGTH_W'(HEADER_LEN))
                begin
                    res0       = make_result(ST_SHORT, 16'd0);
                    n_results  = 2'd1;
                    phase_next = PH_IDLE;
                end
                else if (hp < 3'd4)
                begin
                    if (data_byte != ICON_SIG[hp[1:0]])
                    begin
                        res0       = make_result(ST_SIG, 16'd0);
                        n_results  = 2'd1;
                        phase_next = PH_IDLE;
                    end
                end
                else if (hp == 3'd4)
                begin
                    count_next = {8'd0, data_byte};
                end
                else
                begin
                    count_next   = hdr_count;
                    num_next     = 16'd0;
                    ent_pos_next = 4'd0;
                    if (hdr_count == 16'd0)
                    begin
                        res0       = make_result(ST_DONE, 16'd0);
                        n_results  = 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else if (file_length < FILE_LENGTH_W'(FIRST_END))
                    begin
                        res0       = make_result(ST_TRUNC, 16'd0);
                        n_results  = 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_ENTRY;
                    end
                end
            end
            PH_ENTRY:
            begin
                ent_pos_next = ep + 4'd1;
                buf_we       = (ep != 4'(ENTRY_LEN - 1));
                if (ep == 4'd3 && data_byte != 8'd0)
                begin
                    res0       = make_result(ST_RSV, en);
                    n_results  = 2'd1;
                    phase_next = PH_IDLE;
                end
                else if (ep == 4'(ENTRY_LEN - 1))
                begin
                    if (pay_bad)
                    begin
                        res0       = make_result(ST_PAYLOAD, en);
                        n_results  = 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res0      = ent_res;
                        n_results = 2'd1;
                        num_next  = en1;
                        if (en1 >= ec)
                        begin
                            res1       = make_result(ST_DONE, ec);
                            n_results  = 2'd2;
                            phase_next = PH_IDLE;
                        end
                        else if ({10'd0, next_end} > file_length)
                        begin
                            res1       = make_result(ST_TRUNC, en1);
                            n_results  = 2'd2;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase

        res0.last_of_run = (n_results == 2'd1);
        res1.last_of_run = (n_results == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_pos_reg <= 3'd0;
            count_reg   <= 16'd0;
            num_reg     <= 16'd0;
            ent_pos_reg <= 4'd0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            hdr_pos_reg <= hdr_pos_next;
            count_reg   <= count_next;
            num_reg     <= num_next;
            ent_pos_reg <= ent_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && buf_we)
        begin
            buf_reg[ep] <= data_byte;
        end
    end

endmodule

`default_nettype wire

// File: rtl/icodp_out_queue.sv
`default_nettype none

module icodp_out_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               offer,
    input  wire logic [1:0]         n_results,
    input  wire icodp_pkg::result_t res0,
    input  wire icodp_pkg::result_t res1,
    input  wire logic               result_ready,
    output logic                    taken,
    output logic                    head_valid,
    output icodp_pkg::result_t      head
);
    import icodp_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;
    logic [1:0] c1;
    logic [1:0] push_n;

    assign head_valid = (count_reg != 2'd0);
    assign head       = slot0_reg;
    assign pop        = head_valid && result_ready;
    assign c1         = count_reg - {1'b0, pop};
    // Take the whole group of results from one byte, or none of it.
    assign taken      = offer && (({1'b0, c1} + {1'b0, n_results}) <= 3'd2);
    assign push_n     = taken ? n_results : 2'd0;
    assign count_next = c1 + push_n;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (c1 == 2'd0)
        begin
            slot0_next = res0;
            slot1_next = res1;
        end
        else if (c1 == 2'd1)
        begin
            slot0_next = pop ? slot1_reg : slot0_reg;
            slot1_next = res0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// File: rtl/ico_directory_parser_core.sv
// Icon directory parser. Bytes of an icon file enter one request at a time on the
// byte channel (byte_valid/byte_ready, data_byte, file_start). file_start marks the
// first byte of a new file and restarts the parse. The file's total length is set
// through cfg_wr_en/cfg_wr_data; the user must set it only while no request is in
// flight, which the block does not enforce. Results leave on the result channel
// (result_valid/result_ready): one entry result per directory entry, then a done
// result, or a single error result after which bytes are dropped until the next
// file start. At most two results come from one byte; last_of_run marks the last.
// An accepted byte is held in the input register, and its results are registered
// in the result queue before they reach the ports.
// Throughput: one byte per cycle while result_ready stays high. A byte sits in the
// input register, and the parser decodes it combinationally into a two-slot result
// queue. A byte with two results ends the directory, so the bytes after it add at
// most one result each and the input does not wait while result_ready stays high.
// Stalls: when result_ready is low the queue fills, the input register holds,
// and byte_ready drops; nothing is lost or repeated.
// Reset: the parser waits for byte 0 of a header, so the first byte after reset
// starts a file even without file_start; file_length resets to zero.
`default_nettype none

module ico_directory_parser_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [icodp_pkg::FILE_LENGTH_W-1:0] cfg_wr_data,
    input  wire logic                                byte_valid,
    output logic                                     byte_ready,
    input  wire logic [7:0]                          data_byte,
    input  wire logic                                file_start,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic [2:0]                               status,
    output logic [15:0]                              entry_index,
    output logic [8:0]                               width,
    output logic [8:0]                               height,
    output logic [7:0]                               color_count,
    output logic [15:0]                              planes,
    output logic [15:0]                              bits_per_pixel,
    output logic [icodp_pkg::FILE_LENGTH_W-1:0]      payload_length,
    output logic [icodp_pkg::FILE_LENGTH_W-1:0]      payload_offset,
    output logic                                     last_of_run
);
    import icodp_pkg::*;

    logic [FILE_LENGTH_W-1:0] file_length_reg;
    logic                     stage_valid_reg, stage_valid_next;
    logic [7:0]               stage_byte_reg;
    logic                     stage_start_reg;
    logic                     accept;
    logic                     taken;
    logic [1:0]               n_results;
    result_t                  res0;
    result_t                  res1;
    result_t                  head;

    // The input register frees up whenever its byte moves into the queue.
    assign byte_ready       = !stage_valid_reg || taken;
    assign accept           = byte_valid && byte_ready;
    assign stage_valid_next = accept ? 1'b1 : (taken ? 1'b0 : stage_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            file_length_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (cfg_wr_en)
            begin
                file_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg  <= data_byte;
            stage_start_reg <= file_start;
        end
    end

    icodp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (taken),
        .data_byte   (stage_byte_reg),
        .file_start  (stage_start_reg),
        .file_length (file_length_reg),
        .n_results   (n_results),
        .res0        (res0),
        .res1        (res1)
    );

    icodp_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .offer        (stage_valid_reg),
        .n_results    (n_results),
        .res0         (res0),
        .res1         (res1),
        .result_ready (result_ready),
        .taken        (taken),
        .head_valid   (result_valid),
        .head         (head)
    );

    assign status         = head.status;
    assign entry_index    = head.entry_index;
    assign width          = head.width;
    assign height         = head.height;
    assign color_count    = head.color_count;
    assign planes         = head.planes;
    assign bits_per_pixel = head.bits_per_pixel;
    assign payload_length = head.payload_length;
    assign payload_offset = head.payload_offset;
    assign last_of_run    = head.last_of_run;

endmodule

`default_nettype wire

// File: tb/icodp_result_checker.sv
`default_nettype none

// Watches both channels of the icon directory parser. Every accepted request is run
// through a cycle-free model of the parser, and the results it should cause are
// queued. Every accepted result is compared field by field with the oldest one.
module icodp_result_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [icodp_pkg::FILE_LENGTH_W-1:0] cfg_wr_data,
    input  wire logic                                byte_valid,
    input  wire logic                                byte_ready,
    input  wire logic [7:0]                          data_byte,
    input  wire logic                                file_start,
    input  wire logic                                result_valid,
    input  wire logic                                result_ready,
    input  wire logic [2:0]                          status,
    input  wire logic [15:0]                         entry_index,
    input  wire logic [8:0]                          width,
    input  wire logic [8:0]                          height,
    input  wire logic [7:0]                          color_count,
    input  wire logic [15:0]                         planes,
    input  wire logic [15:0]                         bits_per_pixel,
    input  wire logic [icodp_pkg::FILE_LENGTH_W-1:0] payload_length,
    input  wire logic [icodp_pkg::FILE_LENGTH_W-1:0] payload_offset,
    input  wire logic                                last_of_run,
    output int                                       mismatch_count,
    output int                                       pending
);

    import icodp_pkg::*;

    // Signature bytes 00 00 01 00, byte 0 in the low bits.
    localparam logic [31:0] ICON_MAGIC = 32'h0001_0000;

    result_t                  expected_results[$];
    phase_t                   parse_phase;
    logic [2:0]               hdr_pos;
    logic [16:0]              entry_count;
    logic [16:0]              entry_num;
    logic [3:0]               ent_pos;
    logic [7:0]               entry_bytes[16];
    logic [FILE_LENGTH_W-1:0] file_length;

    function automatic result_t status_only(input status_t st, input logic [16:0] idx);
        result_t r;
        r             = '0;
        r.status      = st;
        r.entry_index = idx[15:0];
        return r;
    endfunction

    // True when directory entry k ends inside the file.
    function automatic bit entry_fits(input logic [16:0] k);
        return (64'd22 + 64'd16 * k) <= {33'd0, file_length};
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic fs);
        result_t     r;
        logic [31:0] len;
        logic [31:0] off;
        logic [3:0]  p;
        int          queued_before;
        queued_before = expected_results.size();
        if (fs) begin
            parse_phase = PH_HEADER;
            hdr_pos     = '0;
            entry_count = '0;
            entry_num   = '0;
            ent_pos     = '0;
        end
        case (parse_phase)
            PH_HEADER: begin
                if (hdr_pos == 3'd0 && file_length < HEADER_LEN) begin
                    expected_results.push_back(status_only(ST_SHORT, '0));
                    parse_phase = PH_IDLE;
                end else if (hdr_pos < 3'd4) begin
                    if (b != ICON_MAGIC[8*hdr_pos +: 8]) begin
                        expected_results.push_back(status_only(ST_SIG, '0));
                        parse_phase = PH_IDLE;
                    end
                end else if (hdr_pos == 3'd4) begin
                    entry_count = {9'd0, b};
                end else begin
                    entry_count[15:8] = b;
                    entry_num         = '0;
                    ent_pos           = '0;
                    if (entry_count == 0) begin
                        expected_results.push_back(status_only(ST_DONE, '0));
                        parse_phase = PH_IDLE;
                    end else if (!entry_fits('0)) begin
                        expected_results.push_back(status_only(ST_TRUNC, '0));
                        parse_phase = PH_IDLE;
                    end else begin
                        parse_phase = PH_ENTRY;
                    end
                end
                hdr_pos = hdr_pos + 3'd1;
            end
            PH_ENTRY: begin
                p              = ent_pos;
                entry_bytes[p] = b;
                if (p == 4'd3 && b != 8'd0) begin
                    expected_results.push_back(status_only(ST_RSV, entry_num));
                    parse_phase = PH_IDLE;
                end else if (p == 4'd15) begin
                    len = {entry_bytes[11], entry_bytes[10], entry_bytes[9], entry_bytes[8]};
                    off = {entry_bytes[15], entry_bytes[14], entry_bytes[13], entry_bytes[12]};
                    if (len[31] || off[31] ||
                        ({32'd0, off} + {32'd0, len}) > {33'd0, file_length}) begin
                        expected_results.push_back(status_only(ST_PAYLOAD, entry_num));
                        parse_phase = PH_IDLE;
                    end else begin
                        r                = status_only(ST_ENTRY, entry_num);
                        r.width          = (entry_bytes[0] == 8'd0) ? 9'd256
                                                                    : {1'b0, entry_bytes[0]};
                        r.height         = (entry_bytes[1] == 8'd0) ? 9'd256
                                                                    : {1'b0, entry_bytes[1]};
                        r.color_count    = entry_bytes[2];
                        r.planes         = {entry_bytes[5], entry_bytes[4]};
                        r.bits_per_pixel = {entry_bytes[7], entry_bytes[6]};
                        r.payload_length = len[30:0];
                        r.payload_offset = off[30:0];
                        expected_results.push_back(r);
                        entry_num = entry_num + 17'd1;
                        if (entry_num >= entry_count) begin
                            expected_results.push_back(status_only(ST_DONE, entry_count));
                            parse_phase = PH_IDLE;
                        end else if (!entry_fits(entry_num)) begin
                            expected_results.push_back(status_only(ST_TRUNC, entry_num));
                            parse_phase = PH_IDLE;
                        end
                    end
                end
                ent_pos = p + 4'd1;
            end
            default: ;
        endcase
        // The final result of this byte carries the end-of-run flag.
        if (expected_results.size() > queued_before) begin
            r             = expected_results.pop_back();
            r.last_of_run = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        if (!rst_n) begin
            expected_results.delete();
            parse_phase = PH_HEADER;
            hdr_pos     = '0;
            entry_count = '0;
            entry_num   = '0;
            ent_pos     = '0;
            file_length = '0;
            foreach (entry_bytes[i])
                entry_bytes[i] = '0;
        end else begin
            // Results are taken off the queue before this edge's request adds any.
            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: status expected none got %0h", $time, status);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("entry_index", want.entry_index, entry_index);
                    compare_field("width", want.width, width);
                    compare_field("height", want.height, height);
                    compare_field("color_count", want.color_count, color_count);
                    compare_field("planes", want.planes, planes);
                    compare_field("bits_per_pixel", want.bits_per_pixel, bits_per_pixel);
                    compare_field("payload_length", want.payload_length, payload_length);
                    compare_field("payload_offset", want.payload_offset, payload_offset);
                    compare_field("last_of_run", want.last_of_run, last_of_run);
                end
            end
            if (cfg_wr_en)
                file_length = cfg_wr_data;
            if (byte_valid && byte_ready)
                parse_byte(data_byte, file_start);
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

// Top of the icon directory parser bench. This module only makes stimulus and
// gives the verdict; the checker beside the parser predicts every result and
// counts mismatches.
module testbench;

    import icodp_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [FILE_LENGTH_W-1:0] cfg_wr_data;
    logic                     byte_valid;
    logic                     byte_ready;
    logic [7:0]               data_byte;
    logic                     file_start;
    logic                     result_valid;
    logic                     result_ready;
    logic [2:0]               status;
    logic [15:0]              entry_index;
    logic [8:0]               width;
    logic [8:0]               height;
    logic [7:0]               color_count;
    logic [15:0]              planes;
    logic [15:0]              bits_per_pixel;
    logic [FILE_LENGTH_W-1:0] payload_length;
    logic [FILE_LENGTH_W-1:0] payload_offset;
    logic                     last_of_run;
    int                       mismatch_count;
    int                       pending;

    // Chance, in percent, that the byte sender or the result receiver idles in a cycle.
    int                       tx_idle_pct;
    int                       rx_idle_pct;

    // The bytes of the file that is about to be sent.
    logic [7:0]               file_bytes[$];

    always #6 clk = ~clk;

    ico_directory_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .data_byte      (data_byte),
        .file_start     (file_start),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .status         (status),
        .entry_index    (entry_index),
        .width          (width),
        .height         (height),
        .color_count    (color_count),
        .planes         (planes),
        .bits_per_pixel (bits_per_pixel),
        .payload_length (payload_length),
        .payload_offset (payload_offset),
        .last_of_run    (last_of_run)
    );

    icodp_result_checker results_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .data_byte      (data_byte),
        .file_start     (file_start),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .status         (status),
        .entry_index    (entry_index),
        .width          (width),
        .height         (height),
        .color_count    (color_count),
        .planes         (planes),
        .bits_per_pixel (bits_per_pixel),
        .payload_length (payload_length),
        .payload_offset (payload_offset),
        .last_of_run    (last_of_run),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // The receiver decides on every falling edge whether it takes a result in the
    // next cycle. With rx_idle_pct at zero it never stalls.
    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Offers one byte request and returns at the falling edge after it was taken.
    // Idle cycles, if any, come before the request is raised, so valid never drops
    // while a request is waiting.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        file_start <= fs;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sends the staged file; only its first byte is marked as a file start.
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == 0);
    endtask

    // Holds the sender off until every predicted result has come out, then keeps
    // waiting so that a byte that causes no result has also cleared.
    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // The parser must be idle when this is called.
    task automatic set_file_length(input logic [FILE_LENGTH_W-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stages a well-formed icon directory with random content for the given file
    // length, and now and then breaks it: a wrong signature byte, a nonzero reserved
    // byte, a payload outside the file, or a file cut off before its end. Entry
    // counts are mostly small, but some exceed what fits so the truncation check is
    // reached, and some are random 16-bit values that are seldom finished.
    task automatic build_file(input logic [FILE_LENGTH_W-1:0] flen);
        int          fit;
        int          count;
        int          n_emit;
        int          fault;
        int          bad_ent;
        int          sel;
        int          pos;
        logic [31:0] off;
        logic [31:0] len;
        fit   = (flen >= FIRST_END) ? (flen - HEADER_LEN) / ENTRY_LEN : 0;
        fault = $urandom_range(0, 9);
        sel   = $urandom_range(0, 99);
        if (sel < 8)
            count = 0;
        else if (sel < 20)
            count = $urandom_range(0, 65535);
        else if (sel < 32)
            count = fit + 1;
        else
            count = (fit == 0) ? 0 : $urandom_range(1, (fit < 3) ? fit : 3);

        file_bytes = '{8'h00, 8'h00, 8'h01, 8'h00};
        if (fault == 0) begin
            pos             = $urandom_range(0, 3);
            file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
        end
        file_bytes.push_back(count[7:0]);
        file_bytes.push_back(count[15:8]);

        n_emit = (count < fit) ? count : fit;
        if (n_emit > 3)
            n_emit = 3;
        bad_ent = $urandom_range(0, 2);
        for (int i = 0; i < n_emit; i++) begin
            // A stored width or height of zero stands for 256 pixels.
            file_bytes.push_back(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
            file_bytes.push_back(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
            file_bytes.push_back(8'($urandom_range(0, 255)));
            file_bytes.push_back((fault == 1 && i == bad_ent) ? 8'($urandom_range(1, 255))
                                                               : 8'h00);
            for (int j = 0; j < 4; j++)
                file_bytes.push_back(8'($urandom_range(0, 255)));
            off = $urandom_range(0, flen);
            len = $urandom_range(0, flen - off);
            if (fault == 2 && i == bad_ent) begin
                case ($urandom_range(0, 2))
                    0:       len[31] = 1'b1;
                    1:       off[31] = 1'b1;
                    default: len = flen - off + 32'd1 + $urandom_range(0, 15);
                endcase
            end
            for (int j = 0; j < 4; j++)
                file_bytes.push_back(len[8*j +: 8]);
            for (int j = 0; j < 4; j++)
                file_bytes.push_back(off[8*j +: 8]);
        end

        if (fault == 3 && file_bytes.size() > 1) begin
            pos        = $urandom_range(1, file_bytes.size() - 1);
            file_bytes = file_bytes[0:pos-1];
        end
    endtask

    initial begin
        int                       sent;
        int                       waited;
        logic [FILE_LENGTH_W-1:0] flen;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        byte_valid   = 1'b0;
        data_byte    = '0;
        file_start   = 1'b0;
        result_ready = 1'b1;
        tx_idle_pct  = 26;
        rx_idle_pct  = 84;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. The file length is still zero from reset, so the first
        // byte, even without a file start, must be reported as a file too short;
        // the byte after it is ignored.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_idle();

        // With the shortest legal file, an empty directory finishes on byte 5, a
        // wrong byte in each signature position is caught as it arrives, and one
        // entry no longer fits.
        set_file_length(FILE_LENGTH_W'(HEADER_LEN));
        file_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00};
        send_file();
        file_bytes = '{8'hFF};
        send_file();
        file_bytes = '{8'h00, 8'h80};
        send_file();
        file_bytes = '{8'h00, 8'h00, 8'hFE};
        send_file();
        file_bytes = '{8'h00, 8'h00, 8'h01, 8'h01};
        send_file();
        file_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00};
        send_file();

        // Random part, in three idling patterns: a fast sender against a busy
        // receiver, then the reverse, then both at full rate. Each pattern runs
        // three file lengths, one of them the largest there is.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 26;
                    rx_idle_pct = 84;
                end
                1: begin
                    tx_idle_pct = 84;
                    rx_idle_pct = 26;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int setting = 0; setting < 3; setting++) begin
                case (setting)
                    0:       flen = FILE_LENGTH_W'(HEADER_LEN + ENTRY_LEN * $urandom_range(1, 4)
                                                   + $urandom_range(0, 40));
                    1:       flen = '1;
                    default: begin
                        case (mode)
                            0:       flen = FILE_LENGTH_W'($urandom_range(0, HEADER_LEN - 1));
                            1:       flen = FILE_LENGTH_W'(HEADER_LEN
                                            + ENTRY_LEN * $urandom_range(0, 2)
                                            + $urandom_range(0, ENTRY_LEN - 1));
                            default: flen = FILE_LENGTH_W'($urandom_range(FIRST_END, 5000));
                        endcase
                    end
                endcase
                // The sender pauses here until all results are out, so the write
                // lands while the parser is idle.
                wait_idle();
                set_file_length(flen);
                sent = 0;
                while (sent < 45) begin
                    if ($urandom_range(0, 9) == 0) begin
                        // Noise: loose bytes, some of them marked as a file start.
                        repeat ($urandom_range(1, 10)) begin
                            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                            sent++;
                        end
                    end else begin
                        build_file(flen);
                        send_file();
                        sent += file_bytes.size();
                    end
                end
            end
        end

        byte_valid <= 1'b0;
        for (waited = 0; pending != 0 && waited < 20000; waited++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (mismatch_count == 0 && pending == 0)
            $display("ico_directory_parser_core: match");
        else
            $display("ico_directory_parser_core: mismatch");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(12 * 200000);
        $display("ico_directory_parser_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/icodp_pkg.sv
rtl/icodp_parser.sv
rtl/icodp_out_queue.sv
rtl/ico_directory_parser_core.sv
tb/icodp_result_checker.sv
tb/testbench.sv
